>>> src/tapc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tapc_pkg: shared types and constants of the axis-plane triangle clipper
// Holds coordinate widths, register indices and the controller/datapath
// command and status structures.
// ---------------------------------------------------------------------------
package tapc_pkg;

	localparam int CoordWidth = 32;
	localparam int FracBits   = 16;
	// Distances carry one bit of growth for the subtraction and one for the edge difference.
	localparam int DistWidth  = CoordWidth + 2;
	localparam int CntWidth   = $clog2(FracBits + 1);

	localparam logic [1:0] REG_AXIS     = 2'd0;
	localparam logic [1:0] REG_NEGATIVE = 2'd1;
	localparam logic [1:0] REG_EXTENT   = 2'd2;

	// Vertex sources for the output mux.
	localparam logic [2:0] SRC_V0 = 3'd0;
	localparam logic [2:0] SRC_V1 = 3'd1;
	localparam logic [2:0] SRC_V2 = 3'd2;
	localparam logic [2:0] SRC_C0 = 3'd3;
	localparam logic [2:0] SRC_C1 = 3'd4;

	typedef logic signed [CoordWidth-1:0] coord_t;
	typedef coord_t vtx_t [6];

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_vtx;    // capture the input vertex
		logic [1:0] load_slot;   // slot to capture into
		logic       div_start;   // start a division for the selected edge
		logic       div_step;    // one restoring step
		logic       lerp_go;     // one interpolation coordinate
		logic [2:0] lerp_coord;  // coordinate index
		logic       cut_sel;     // which cut vertex is being built
		logic [1:0] edge_a;      // edge start vertex
		logic [1:0] edge_b;      // edge end vertex
		logic       out_load;    // load the output register
		logic [2:0] out_src;     // output vertex source
		logic       out_last;    // last flag for this output
	} tapc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] outside;     // per-vertex outside flags
		logic       div_done;    // fraction is final
	} tapc_sts_t;

endpackage : tapc_pkg
`default_nettype wire

>>> src/tapc_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tapc_datapath: vertex store, distance, divider and interpolation
// Holds the three vertices of a triangle, one shared restoring divider for
// the edge fraction, a one-coordinate-per-cycle interpolator and the output
// register.
// ---------------------------------------------------------------------------
module tapc_datapath (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire tapc_pkg::coord_t  vin [6],
	input  wire  [1:0]             plane_axis,
	input  wire                    plane_negative,
	input  wire  [tapc_pkg::CoordWidth-2:0] half_extent,
	input  wire tapc_pkg::tapc_cmd_t cmd,
	output tapc_pkg::tapc_sts_t    sts,
	output tapc_pkg::coord_t       vout [6],
	output logic                   vout_last
);
	import tapc_pkg::*;

	coord_t                       vtx_q   [3][6];
	coord_t                       cut_q   [2][6];
	logic signed [DistWidth-1:0]  vdist   [3];
	logic [2:0]                   outside_c;
	logic [DistWidth-1:0]         rem_q;
	logic [DistWidth-1:0]         den_q;
	logic [FracBits:0]            frac_q;
	logic [CntWidth-1:0]          cnt_q;
	logic                         busy_q;
	logic [1:0]                   ax;
	logic signed [DistWidth-1:0]  da, db, dn, nm;
	logic [DistWidth:0]           rsh;
	coord_t                       ca, cb;
	logic signed [CoordWidth:0]   diff;
	logic [CoordWidth:0]          mag;
	logic [CoordWidth+FracBits+1:0] prod;
	logic [CoordWidth:0]          pmag;
	logic signed [CoordWidth+1:0] res;

	// Vertex capture.
	always_ff @(posedge clk) begin
		if (cmd.load_vtx) begin
			vtx_q[cmd.load_slot] <= vin;
		end
	end

	// Signed distances of the three stored vertices.
	assign ax = (plane_axis == 2'd3) ? 2'd0 : plane_axis;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vdist[k] = plane_negative
				? -DistWidth'(vtx_q[k][ax]) - DistWidth'({1'b0, half_extent})
				:  DistWidth'(vtx_q[k][ax]) - DistWidth'({1'b0, half_extent});
			outside_c[k] = vdist[k] > 0;
		end
	end

	// Normalise the edge fraction to a non-negative denominator, negating the numerator with it.
	assign da = vdist[cmd.edge_a];
	assign db = vdist[cmd.edge_b];
	always_comb begin
		dn = da - db;
		nm = da;
		if (dn < 0) begin
			dn = -dn;
			nm = -nm;
		end
	end
	assign rsh = {rem_q, 1'b0};

	// Restoring divider, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			frac_q <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else if (cmd.div_start) begin
			if (dn == 0 || nm <= 0) begin
				busy_q <= 1'b0;
				frac_q <= '0;
			end else if (nm >= dn) begin
				busy_q <= 1'b0;
				frac_q <= (FracBits+1)'(1) << FracBits;
			end else begin
				busy_q <= 1'b1;
				frac_q <= '0;
				cnt_q  <= '0;
				rem_q  <= nm;
				den_q  <= dn;
			end
		end else if (cmd.div_step && busy_q) begin
			if (rsh >= {1'b0, den_q}) begin
				rem_q  <= DistWidth'(rsh - {1'b0, den_q});
				frac_q <= {frac_q[FracBits-1:0], 1'b1};
			end else begin
				rem_q  <= rsh[DistWidth-1:0];
				frac_q <= {frac_q[FracBits-1:0], 1'b0};
			end
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CntWidth'(FracBits - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Status back to the controller.
	assign sts = '{outside: outside_c, div_done: !busy_q};

	// Interpolation of one coordinate, truncated toward zero in magnitude.
	assign ca   = vtx_q[cmd.edge_a][cmd.lerp_coord];
	assign cb   = vtx_q[cmd.edge_b][cmd.lerp_coord];
	assign diff = (CoordWidth+1)'(cb) - (CoordWidth+1)'(ca);
	assign mag  = diff[CoordWidth] ? -diff : diff;
	assign prod = (CoordWidth+FracBits+2)'(mag) * (CoordWidth+FracBits+2)'(frac_q);
	assign pmag = prod[CoordWidth+FracBits:FracBits];
	assign res  = diff[CoordWidth]
		? (CoordWidth+2)'(ca) - (CoordWidth+2)'(pmag)
		: (CoordWidth+2)'(ca) + (CoordWidth+2)'(pmag);

	always_ff @(posedge clk) begin
		if (cmd.lerp_go) begin
			cut_q[cmd.cut_sel][cmd.lerp_coord] <= res[CoordWidth-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			vout_last <= cmd.out_last;
			case (cmd.out_src)
				SRC_V1:  vout <= vtx_q[1];
				SRC_V2:  vout <= vtx_q[2];
				SRC_C0:  vout <= cut_q[0];
				SRC_C1:  vout <= cut_q[1];
				default: vout <= vtx_q[0];
			endcase
		end
	end

endmodule : tapc_datapath
`default_nettype wire

>>> src/tapc_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tapc_ctrl: sequencer of the axis-plane triangle clipper
// Counts vertices, runs the cut computations and emits the output sequence
// through the output handshake.
// ---------------------------------------------------------------------------
module tapc_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire                      out_stall,
	input  wire tapc_pkg::tapc_sts_t sts,
	output tapc_pkg::tapc_cmd_t      cmd
);
	import tapc_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLS   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_LERP  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;
	localparam logic [2:0] ST_START = 3'd6;

	logic [2:0] state_q;
	logic [1:0] slot_q;
	logic [2:0] n_q;
	logic [2:0] idx_q;
	logic       cut_q;
	logic [2:0] coord_q;
	logic [1:0] ea_q [2];
	logic [1:0] eb_q [2];
	logic [2:0] src_q [6];
	logic       accept;
	logic       out_take;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd            = '0;
		cmd.load_vtx   = accept;
		cmd.load_slot  = slot_q;
		cmd.edge_a     = ea_q[cut_q];
		cmd.edge_b     = eb_q[cut_q];
		cmd.cut_sel    = cut_q;
		cmd.lerp_coord = coord_q;
		cmd.div_step   = (state_q == ST_DIV);
		cmd.div_start  = (state_q == ST_START);
		cmd.lerp_go    = (state_q == ST_LERP);
		cmd.out_load   = (state_q == ST_EMIT);
		cmd.out_src    = src_q[idx_q];
		cmd.out_last   = (idx_q == n_q - 3'd1);
	end

	// Sequencer state machine; classification plans the edges and the emission order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			n_q     <= '0;
			idx_q   <= '0;
			cut_q   <= 1'b0;
			coord_q <= '0;
			ea_q    <= '{default: '0};
			eb_q    <= '{default: '0};
			src_q   <= '{default: SRC_V0};
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (slot_q == 2'd2 || slot_q == 2'd3) begin
							slot_q  <= '0;
							state_q <= ST_CLS;
						end else begin
							slot_q <= slot_q + 2'd1;
						end
					end
				end
				ST_CLS: begin
					idx_q <= '0;
					cut_q <= 1'b0;
					coord_q <= '0;
					unique case (sts.outside) inside
						3'b000: begin
							n_q <= 3'd3;
							src_q[0] <= SRC_V0; src_q[1] <= SRC_V1; src_q[2] <= SRC_V2;
							state_q <= ST_EMIT;
						end
						3'b111: begin
							state_q <= ST_IDLE;
						end
						3'b001, 3'b010, 3'b100: begin
							n_q <= 3'd6;
							state_q <= ST_START;
							if (sts.outside[0]) begin
								ea_q[0] <= 2'd0; eb_q[0] <= 2'd1;
								ea_q[1] <= 2'd0; eb_q[1] <= 2'd2;
								src_q[0] <= SRC_V1; src_q[1] <= SRC_V2; src_q[2] <= SRC_C0;
								src_q[3] <= SRC_C1; src_q[4] <= SRC_C0; src_q[5] <= SRC_V2;
							end else if (sts.outside[1]) begin
								ea_q[0] <= 2'd1; eb_q[0] <= 2'd0;
								ea_q[1] <= 2'd1; eb_q[1] <= 2'd2;
								src_q[0] <= SRC_C0; src_q[1] <= SRC_V2; src_q[2] <= SRC_V0;
								src_q[3] <= SRC_V2; src_q[4] <= SRC_C0; src_q[5] <= SRC_C1;
							end else begin
								ea_q[0] <= 2'd2; eb_q[0] <= 2'd0;
								ea_q[1] <= 2'd2; eb_q[1] <= 2'd1;
								src_q[0] <= SRC_V0; src_q[1] <= SRC_V1; src_q[2] <= SRC_C0;
								src_q[3] <= SRC_C1; src_q[4] <= SRC_C0; src_q[5] <= SRC_V1;
							end
						end
						default: begin
							// Two outside: the inside vertex starts both edges.
							n_q <= 3'd3;
							state_q <= ST_START;
							src_q[1] <= SRC_C0; src_q[2] <= SRC_C1;
							if (!sts.outside[0]) begin
								ea_q[0] <= 2'd0; eb_q[0] <= 2'd1;
								ea_q[1] <= 2'd0; eb_q[1] <= 2'd2;
								src_q[0] <= SRC_V0;
							end else if (!sts.outside[1]) begin
								ea_q[0] <= 2'd1; eb_q[0] <= 2'd2;
								ea_q[1] <= 2'd1; eb_q[1] <= 2'd0;
								src_q[0] <= SRC_V1;
							end else begin
								ea_q[0] <= 2'd2; eb_q[0] <= 2'd0;
								ea_q[1] <= 2'd2; eb_q[1] <= 2'd1;
								src_q[0] <= SRC_V2;
							end
						end
					endcase
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_done) begin
						state_q <= ST_LERP;
					end
				end
				ST_LERP: begin
					if (coord_q == 3'd5) begin
						coord_q <= '0;
						if (cut_q) begin
							state_q <= ST_EMIT;
						end else begin
							cut_q   <= 1'b1;
							state_q <= ST_START;
						end
					end else begin
						coord_q <= coord_q + 3'd1;
					end
				end
				ST_EMIT: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_take) begin
						if (idx_q == n_q - 3'd1) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 3'd1;
							state_q <= ST_EMIT;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The datapath division is kicked off in the START state, once the edge is set.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LERP) |-> sts.div_done)
		else $error("interpolation started before fraction was ready");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q < n_q))
		else $error("emission index past the run length");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(idx_q))
		else $error("stalled output was dropped");

endmodule : tapc_ctrl
`default_nettype wire

>>> src/triangle_axis_plane_clipper.sv
`default_nettype none
// ---------------------------------------------------------------------------
// triangle_axis_plane_clipper: clips triangles against one axis plane
// Vertices (position and normal) arrive three per triangle on the input
// channel; the clipped vertex stream leaves on the output channel with
// last_of_run marking the final vertex of each triangle.
//
// Input is accepted when in_valid is high and in_stall low; the first two
// vertices of a triangle are stored as they are accepted. The third starts
// the work: classification, then for each cut vertex a start of the shared
// restoring divider, the division (16 quotient bits, one per cycle, then a
// check that it has finished; cut short when the fraction is zero or
// saturates) and the interpolation of six coordinates, one coordinate per
// cycle. Each output vertex is then loaded and presented, and is held for
// as long as out_stall is high. After the third vertex in_stall stays high
// until the triangle is dropped (all vertices outside) or its last output
// vertex has been taken. When the receiver stalls, the output vertex holds.
// Reset clears the vertex counter and the controller; the plane registers
// return to x axis, positive normal, half extent 1.0. Configuration is
// written through cfg_valid/cfg_ready, which is always ready.
// ---------------------------------------------------------------------------
module triangle_axis_plane_clipper (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire [tapc_pkg::CoordWidth-1:0] vert_pos_x,
	input  wire [tapc_pkg::CoordWidth-1:0] vert_pos_y,
	input  wire [tapc_pkg::CoordWidth-1:0] vert_pos_z,
	input  wire [tapc_pkg::CoordWidth-1:0] vert_norm_x,
	input  wire [tapc_pkg::CoordWidth-1:0] vert_norm_y,
	input  wire [tapc_pkg::CoordWidth-1:0] vert_norm_z,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [tapc_pkg::CoordWidth-1:0] out_pos_x,
	output logic [tapc_pkg::CoordWidth-1:0] out_pos_y,
	output logic [tapc_pkg::CoordWidth-1:0] out_pos_z,
	output logic [tapc_pkg::CoordWidth-1:0] out_norm_x,
	output logic [tapc_pkg::CoordWidth-1:0] out_norm_y,
	output logic [tapc_pkg::CoordWidth-1:0] out_norm_z,
	output logic               last_of_run,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire [1:0]          cfg_index,
	input  wire [tapc_pkg::CoordWidth-2:0] cfg_data
);
	import tapc_pkg::*;

	logic [1:0]  plane_axis_q;
	logic        plane_negative_q;
	logic [CoordWidth-2:0] half_extent_q;
	coord_t      vin  [6];
	coord_t      vout [6];
	tapc_cmd_t   cmd;
	tapc_sts_t   sts;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_axis_q     <= 2'd0;
			plane_negative_q <= 1'b0;
			half_extent_q    <= (CoordWidth-1)'(65536);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_AXIS:     plane_axis_q     <= cfg_data[1:0];
				REG_NEGATIVE: plane_negative_q <= cfg_data[0];
				REG_EXTENT:   half_extent_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign vin[0] = vert_pos_x;
	assign vin[1] = vert_pos_y;
	assign vin[2] = vert_pos_z;
	assign vin[3] = vert_norm_x;
	assign vin[4] = vert_norm_y;
	assign vin[5] = vert_norm_z;

	tapc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tapc_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.vin            (vin),
		.plane_axis     (plane_axis_q),
		.plane_negative (plane_negative_q),
		.half_extent    (half_extent_q),
		.cmd            (cmd),
		.sts            (sts),
		.vout           (vout),
		.vout_last      (last_of_run)
	);

	assign out_pos_x  = vout[0];
	assign out_pos_y  = vout[1];
	assign out_pos_z  = vout[2];
	assign out_norm_x = vout[3];
	assign out_norm_y = vout[4];
	assign out_norm_z = vout[5];

endmodule : triangle_axis_plane_clipper
`default_nettype wire
